### rtl/acfb_pkg.sv
// ----------------------------------------------------------------------------
// acfb_pkg: shared types and constants of the IR frame builder
// Holds the request and result word types, the job word that travels
// from the front to the back, and the fixed bytes and codes of the frame.
// ----------------------------------------------------------------------------
package acfb_pkg;

    // One request word, fields in the order of the request interface.
    typedef struct packed {
        logic [2:0] mode_sel;
        logic [1:0] fan_sel;
        logic [7:0] setpoint;
        logic [5:0] toggle_flags;
        logic       power_on;
        logic [3:0] hvane;
        logic       sensor_on;
    } req_t;

    // One result word: a single frame byte with its position marks.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [5:0] byte_index;
        logic [1:0] section_num;
        logic       section_end;
        logic       frame_last;
    } res_t;

    // The request-dependent bytes of the third section.
    typedef struct packed {
        logic [7:0] b21;
        logic [7:0] b22;
        logic [7:0] b24;
        logic [7:0] b25;
        logic [7:0] b29;
        logic [7:0] b32;
        logic [7:0] b33;
    } job_t;

    localparam int JOB_DEPTH = 2;

    localparam logic [5:0] SEC0_END   = 6'd7;
    localparam logic [5:0] SEC1_END   = 6'd15;
    localparam logic [5:0] FRAME_LAST = 6'd34;

    localparam logic [7:0] HDR0      = 8'h11;
    localparam logic [7:0] HDR1      = 8'hDA;
    localparam logic [7:0] HDR2      = 8'h27;
    localparam logic [7:0] SEC0_B4   = 8'hC5;
    localparam logic [7:0] SEC1_B12  = 8'h42;
    localparam logic [7:0] SEC2_B27  = 8'h06;
    localparam logic [7:0] SEC2_B28  = 8'h60;
    localparam logic [7:0] SEC2_B31  = 8'hC0;

    // Mode request codes and their frame encodings.
    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_COOL = 3'd1;
    localparam logic [2:0] MODE_AUTO = 3'd2;
    localparam logic [2:0] MODE_DRY  = 3'd3;
    localparam logic [2:0] MODE_HEAT = 3'd4;
    localparam logic [2:0] MODE_FAN  = 3'd5;

    localparam logic [2:0] MCODE_AUTO = 3'b000;
    localparam logic [2:0] MCODE_DRY  = 3'b010;
    localparam logic [2:0] MCODE_COOL = 3'b011;
    localparam logic [2:0] MCODE_HEAT = 3'b100;
    localparam logic [2:0] MCODE_FAN  = 3'b110;

    // Fan request codes and their frame encodings.
    localparam logic [1:0] FAN_AUTO = 2'd0;
    localparam logic [1:0] FAN_LOW  = 2'd1;
    localparam logic [1:0] FAN_MED  = 2'd2;
    localparam logic [1:0] FAN_HIGH = 2'd3;

    localparam logic [3:0] FCODE_AUTO  = 4'b1010;
    localparam logic [3:0] FCODE_LOW   = 4'd3;
    localparam logic [3:0] FCODE_MED   = 4'd5;
    localparam logic [3:0] FCODE_HIGH  = 4'd7;
    localparam logic [3:0] FCODE_QUIET = 4'b1011;

    // Bit positions within toggle_flags.
    localparam int TF_SWING    = 1;
    localparam int TF_POWERFUL = 2;
    localparam int TF_QUIET    = 3;
    localparam int TF_ECONO    = 4;
    localparam int TF_MOLD     = 5;

    function automatic logic [2:0] mode_code(input logic [2:0] sel);
        logic [2:0] code;
        case (sel)
            MODE_AUTO: code = MCODE_AUTO;
            MODE_DRY:  code = MCODE_DRY;
            MODE_HEAT: code = MCODE_HEAT;
            MODE_FAN:  code = MCODE_FAN;
            default:   code = MCODE_COOL;   // off, cool and unused codes
        endcase
        return code;
    endfunction

    function automatic logic [3:0] fan_code(input logic [1:0] sel);
        logic [3:0] code;
        case (sel)
            FAN_LOW:  code = FCODE_LOW;
            FAN_MED:  code = FCODE_MED;
            FAN_HIGH: code = FCODE_HIGH;
            default:  code = FCODE_AUTO;
        endcase
        return code;
    endfunction

    // Frame byte at a position before checksum insertion.
    function automatic logic [7:0] base_byte(input logic [5:0] idx, input job_t job);
        logic [7:0] b;
        case (idx)
            6'd0, 6'd8, 6'd16:  b = HDR0;
            6'd1, 6'd9, 6'd17:  b = HDR1;
            6'd2, 6'd10, 6'd18: b = HDR2;
            6'd4:  b = SEC0_B4;
            6'd12: b = SEC1_B12;
            6'd21: b = job.b21;
            6'd22: b = job.b22;
            6'd24: b = job.b24;
            6'd25: b = job.b25;
            6'd27: b = SEC2_B27;
            6'd28: b = SEC2_B28;
            6'd29: b = job.b29;
            6'd31: b = SEC2_B31;
            6'd32: b = job.b32;
            6'd33: b = job.b33;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### rtl/acfb_front.sv
// ----------------------------------------------------------------------------
// acfb_front: request decoder
// Clamps the setpoint and packs the request fields into the job bytes.
// ----------------------------------------------------------------------------
module acfb_front (
    input  acfb_pkg::req_t req,
    input  logic [6:0]     temp_min,
    input  logic [6:0]     temp_max,
    output acfb_pkg::job_t job
);
    import acfb_pkg::*;

    logic [7:0] t_lo;
    logic [7:0] t_clamp;
    logic [3:0] fan_nibble;

    always_comb
    begin
        // The minimum is applied first, so an inverted range yields the maximum.
        t_lo    = (req.setpoint < {1'b0, temp_min}) ? {1'b0, temp_min} : req.setpoint;
        t_clamp = (t_lo > {1'b0, temp_max}) ? {1'b0, temp_max} : t_lo;

        fan_nibble = req.toggle_flags[TF_QUIET] ? FCODE_QUIET : fan_code(req.fan_sel);

        job.b21 = {1'b0, mode_code(req.mode_sel), 1'b1, 2'b00, req.power_on};
        job.b22 = {t_clamp[6:0], 1'b0};
        job.b24 = {fan_nibble, {4{req.toggle_flags[TF_SWING]}}};
        job.b25 = {4'h0, req.hvane};
        job.b29 = {2'b00, req.toggle_flags[TF_QUIET], 4'h0,
                   req.toggle_flags[TF_POWERFUL]};
        job.b32 = {5'h00, req.toggle_flags[TF_ECONO], req.sensor_on, 1'b0};
        job.b33 = {6'h00, req.toggle_flags[TF_MOLD], 1'b0};
    end

endmodule

### rtl/acfb_queue.sv
// ----------------------------------------------------------------------------
// acfb_queue: job queue
// A two-entry first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module acfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  acfb_pkg::job_t wr_data,
    input  logic           rd_en,
    output acfb_pkg::job_t rd_data,
    output logic           full,
    output logic           nempty
);
    import acfb_pkg::*;

    job_t       mem_reg [JOB_DEPTH];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = (cnt_reg == 2'(JOB_DEPTH));
    assign nempty  = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr_en ? ~wp_reg : wp_reg;
        rp_next  = rd_en ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/acfb_back.sv
// ----------------------------------------------------------------------------
// acfb_back: frame sequencer
// Walks the 35 byte positions of a job, inserts the section checksums and
// holds each byte in an output register until it is taken.
// ----------------------------------------------------------------------------
module acfb_back (
    input  logic           clk,
    input  logic           rst_n,
    input  acfb_pkg::job_t q_data,
    input  logic           q_nempty,
    output logic           q_pop,
    output acfb_pkg::res_t result,
    output logic           empty,
    input  logic           pop
);
    import acfb_pkg::*;

    logic       active_reg, active_next;
    logic [5:0] idx_reg, idx_next;
    logic [7:0] sum_reg, sum_next;
    job_t       job_reg, job_next;
    res_t       out_reg, out_next;
    logic       out_valid_reg, out_valid_next;

    logic       adv;
    logic       emit;
    logic       is_end;
    logic       take;
    logic [7:0] base;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign q_pop  = take;

    always_comb
    begin
        adv    = !out_valid_reg || pop;
        emit   = active_reg && adv;
        is_end = (idx_reg == SEC0_END) || (idx_reg == SEC1_END) || (idx_reg == FRAME_LAST);
        base   = base_byte(idx_reg, job_reg);
        take   = q_nempty && (!active_reg || (emit && idx_reg == FRAME_LAST));

        active_next    = active_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        job_next       = job_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !pop;

        if (emit)
        begin
            out_next.frame_byte  = is_end ? sum_reg : base;
            out_next.byte_index  = idx_reg;
            out_next.section_num = (idx_reg <= SEC0_END) ? 2'd0 :
                                   (idx_reg <= SEC1_END) ? 2'd1 : 2'd2;
            out_next.section_end = is_end;
            out_next.frame_last  = (idx_reg == FRAME_LAST);
            out_valid_next       = 1'b1;
            sum_next             = is_end ? 8'h00 : sum_reg + base;
            idx_next             = idx_reg + 6'd1;
            if (idx_reg == FRAME_LAST)
            begin
                active_next = 1'b0;
            end
        end

        if (take)
        begin
            job_next    = q_data;
            idx_next    = 6'd0;
            sum_next    = 8'h00;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
        sum_reg <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg <= FRAME_LAST)
        else $error("byte position ran past the end of the frame");

    a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.section_end) |->
        (out_reg.byte_index == SEC0_END || out_reg.byte_index == SEC1_END ||
         out_reg.byte_index == FRAME_LAST))
        else $error("section end marked at a non-checksum position");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting frame byte changed before it was taken");

    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg != FRAME_LAST) |=> (idx_reg == $past(idx_reg) + 6'd1))
        else $error("byte position skipped within a frame");

endmodule

### rtl/ac_ir_frame_builder.sv
// The first frame byte passes through the job queue, the back's job register and
// the output register. Throughput: one frame byte per cycle while pop takes each
// byte, set by the back sequencer that walks the 35 byte positions one per cycle.
// Up to two requests wait in the job queue while a frame is being sent.
// Reset (rst_n low, asynchronous) empties the queue and output register and sets
// temp_min to 10 and temp_max to 32.
// ----------------------------------------------------------------------------
// ac_ir_frame_builder: air-conditioner remote-control frame builder
// Turns one request word into the 35-byte, three-section remote frame,
// delivered as 35 result words with section and end marks.
// ----------------------------------------------------------------------------
module ac_ir_frame_builder (
    input  logic           clk,
    input  logic           rst_n,
    // request side
    input  acfb_pkg::req_t request,
    input  logic           push,
    output logic           full,
    // result side
    output acfb_pkg::res_t result,
    output logic           empty,
    input  logic           pop,
    // configuration port
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import acfb_pkg::*;

    // Register indexes on the configuration port, taken from paddr[2].
    localparam logic REG_TEMP_MIN = 1'b0;
    localparam logic REG_TEMP_MAX = 1'b1;

    logic [6:0] temp_min_reg, temp_min_next;
    logic [6:0] temp_max_reg, temp_max_next;
    logic       cfg_wr;

    job_t front_job;
    job_t q_data;
    logic q_full;
    logic q_nempty;
    logic q_pop;
    logic q_push;

    // The configuration port never stalls. A write lands on the access cycle.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        temp_min_next = temp_min_reg;
        temp_max_next = temp_max_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_TEMP_MIN: temp_min_next = pwdata[6:0];
                REG_TEMP_MAX: temp_max_next = pwdata[6:0];
                default:      temp_min_next = temp_min_reg;
            endcase
        end
    end

    // Reads return the register value zero-extended to the data width.
    always_comb
    begin
        case (paddr[2])
            REG_TEMP_MIN: prdata = {25'd0, temp_min_reg};
            REG_TEMP_MAX: prdata = {25'd0, temp_max_reg};
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_min_reg <= 7'd10;
            temp_max_reg <= 7'd32;
        end
        else
        begin
            temp_min_reg <= temp_min_next;
            temp_max_reg <= temp_max_next;
        end
    end

    // The front decodes a request in the cycle it is accepted and the job
    // queue captures the packed bytes, so the input side is only held off
    // when two jobs are already waiting behind the frame in flight.
    assign full   = q_full;
    assign q_push = push && !q_full;

    acfb_front u_front (
        .req      (request),
        .temp_min (temp_min_reg),
        .temp_max (temp_max_reg),
        .job      (front_job)
    );

    acfb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (front_job),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .nempty  (q_nempty)
    );

    // The back takes the next job in the same cycle the last byte of the
    // current frame is issued, so consecutive frames run without a gap.
    acfb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_data),
        .q_nempty (q_nempty),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

### tb/sv/acfb_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// acfb_frame_checker: frame prediction and comparison for the IR frame builder
// Watches the request, result and register channels, builds the expected
// 35-word frame for every accepted request, and compares each accepted
// result word field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module acfb_frame_checker #(
    parameter logic [2:0] TEMP_MIN_ADDR = 3'd0,
    parameter logic [2:0] TEMP_MAX_ADDR = 3'd4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  acfb_pkg::req_t request,
    input  logic           push,
    input  logic           full,
    input  acfb_pkg::res_t result,
    input  logic           empty,
    input  logic           pop,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    input  logic [31:0]    prdata,
    input  logic           pready,
    output int             mismatches,
    output int             outstanding,
    output int             requests_seen,
    output int             words_seen
);
    import acfb_pkg::*;

    localparam int         FRAME_WORDS    = 35;
    localparam logic [6:0] TEMP_MIN_RESET = 7'd10;
    localparam logic [6:0] TEMP_MAX_RESET = 7'd32;
    localparam logic [1:0] SECTION_FIRST  = 2'd0;
    localparam logic [1:0] SECTION_SECOND = 2'd1;
    localparam logic [1:0] SECTION_THIRD  = 2'd2;

    logic [6:0] limit_lo = TEMP_MIN_RESET;
    logic [6:0] limit_hi = TEMP_MAX_RESET;
    res_t       frame_words[$];
    int         fail_total   = 0;
    int         req_total    = 0;
    int         word_total   = 0;
    int         waiting      = 0;

    assign mismatches    = fail_total;
    assign outstanding   = waiting;
    assign requests_seen = req_total;
    assign words_seen    = word_total;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_total++;
        end
    endtask

    // Builds the whole frame for one request and queues its 35 words.
    function automatic void predict_frame(input req_t r);
        logic [7:0] fb [FRAME_WORDS];
        logic [7:0] temp;
        logic [7:0] acc;
        logic [2:0] mcode;
        logic [3:0] fcode;
        res_t       w;

        temp = r.setpoint;
        if (temp < {1'b0, limit_lo})
            temp = {1'b0, limit_lo};
        if (temp > {1'b0, limit_hi})
            temp = {1'b0, limit_hi};

        case (r.mode_sel)
            MODE_AUTO: mcode = MCODE_AUTO;
            MODE_DRY:  mcode = MCODE_DRY;
            MODE_HEAT: mcode = MCODE_HEAT;
            MODE_FAN:  mcode = MCODE_FAN;
            default:   mcode = MCODE_COOL;
        endcase

        case (r.fan_sel)
            FAN_LOW:  fcode = FCODE_LOW;
            FAN_MED:  fcode = FCODE_MED;
            FAN_HIGH: fcode = FCODE_HIGH;
            default:  fcode = FCODE_AUTO;
        endcase
        if (r.toggle_flags[TF_QUIET])
            fcode = FCODE_QUIET;

        for (int k = 0; k < FRAME_WORDS; k++)
            fb[k] = 8'h00;
        fb[0]  = HDR0;  fb[1]  = HDR1;  fb[2]  = HDR2;  fb[4]  = SEC0_B4;
        fb[8]  = HDR0;  fb[9]  = HDR1;  fb[10] = HDR2;  fb[12] = SEC1_B12;
        fb[16] = HDR0;  fb[17] = HDR1;  fb[18] = HDR2;
        fb[27] = SEC2_B27;  fb[28] = SEC2_B28;  fb[31] = SEC2_B31;

        fb[21] = {1'b0, mcode, 1'b1, 2'b00, r.power_on};
        fb[22] = temp << 1;
        fb[24] = {fcode, r.toggle_flags[TF_SWING] ? 4'hF : 4'h0};
        fb[25] = {4'h0, r.hvane};
        fb[29] = {2'b00, r.toggle_flags[TF_QUIET], 4'b0000, r.toggle_flags[TF_POWERFUL]};
        fb[32] = {5'b00000, r.toggle_flags[TF_ECONO], r.sensor_on, 1'b0};
        fb[33] = {6'b000000, r.toggle_flags[TF_MOLD], 1'b0};

        // Each section closes with the wrapping sum of the bytes since the last close.
        acc = 8'h00;
        for (int k = 0; k < FRAME_WORDS; k++)
        begin
            if (k == SEC0_END || k == SEC1_END || k == FRAME_LAST)
            begin
                fb[k] = acc;
                acc = 8'h00;
            end
            else
                acc = acc + fb[k];
        end

        for (int k = 0; k < FRAME_WORDS; k++)
        begin
            w.frame_byte  = fb[k];
            w.byte_index  = 6'(k);
            w.section_num = (k <= SEC0_END) ? SECTION_FIRST :
                            (k <= SEC1_END) ? SECTION_SECOND : SECTION_THIRD;
            w.section_end = (k == SEC0_END || k == SEC1_END || k == FRAME_LAST);
            w.frame_last  = (k == FRAME_LAST);
            frame_words.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        res_t want;
        if (!rst_n)
        begin
            frame_words.delete();
            limit_lo = TEMP_MIN_RESET;
            limit_hi = TEMP_MAX_RESET;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (frame_words.size() == 0)
                begin
                    $error("unexpected result word: byte 0x%0h at index %0d",
                           result.frame_byte, result.byte_index);
                    fail_total++;
                end
                else
                begin
                    want = frame_words.pop_front();
                    check_field("frame_byte",  32'(want.frame_byte),
                                32'(result.frame_byte));
                    check_field("byte_index",  32'(want.byte_index),
                                32'(result.byte_index));
                    check_field("section_num", 32'(want.section_num),
                                32'(result.section_num));
                    check_field("section_end", 32'(want.section_end),
                                32'(result.section_end));
                    check_field("frame_last",  32'(want.frame_last),
                                32'(result.frame_last));
                end
                word_total++;
            end

            if (push && !full)
            begin
                predict_frame(request);
                req_total++;
            end

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == TEMP_MIN_ADDR)
                        limit_lo = pwdata[6:0];
                    else if (paddr == TEMP_MAX_ADDR)
                        limit_hi = pwdata[6:0];
                end
                else if (paddr == TEMP_MIN_ADDR)
                    check_field("prdata temp_min", {25'd0, limit_lo}, prdata);
                else if (paddr == TEMP_MAX_ADDR)
                    check_field("prdata temp_max", {25'd0, limit_hi}, prdata);
            end
        end
        waiting = frame_words.size();
    end

endmodule

### tb/sv/tb_ac_ir_frame_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ac_ir_frame_builder: top-level testbench of the IR frame builder
// Drives request words in random bursts, drains result words with a stall
// pattern of its own, and reprograms the temperature limits between phases.
// A checker instance beside the block predicts every frame and reports
// mismatches; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_ac_ir_frame_builder;
    import acfb_pkg::*;

    // Register map: one 32-bit register every four bytes.
    localparam logic [2:0] TEMP_MIN_ADDR = 3'd0;
    localparam logic [2:0] TEMP_MAX_ADDR = 3'd4;

    // Mode request codes that the block has no name for; both act as cool.
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 53;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 120;
    localparam int LIMIT_CYCLES  = 500000;

    logic        clk;
    logic        rst_n;
    req_t        request;
    logic        push;
    logic        full;
    res_t        result;
    logic        empty;
    logic        pop;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int outstanding;
    int requests_seen;
    int words_seen;
    int cycle_count = 0;

    ac_ir_frame_builder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    acfb_frame_checker #(
        .TEMP_MIN_ADDR (TEMP_MIN_ADDR),
        .TEMP_MAX_ADDR (TEMP_MAX_ADDR)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .push          (push),
        .full          (full),
        .result        (result),
        .empty         (empty),
        .pop           (pop),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .words_seen    (words_seen)
    );

    // 8 ns clock. Stimulus changes on the falling edge so that every input is
    // stable well before the rising edge where the block and checker sample.
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, outstanding);
            $display("ac_ir_frame_builder test failed");
            $finish;
        end
    end

    function automatic req_t make_request(input logic [2:0] mode, input logic [1:0] fan,
                                          input logic [7:0] temp, input logic [5:0] flags,
                                          input logic pwr, input logic [3:0] vane,
                                          input logic sens);
        req_t r;
        r.mode_sel     = mode;
        r.fan_sel      = fan;
        r.setpoint     = temp;
        r.toggle_flags = flags;
        r.power_on     = pwr;
        r.hvane        = vane;
        r.sensor_on    = sens;
        return r;
    endfunction

    // Fully random request, except that half the time the setpoint lands
    // within a few degrees of the current limits so that both clamp edges
    // and the pass-through band are hit often.
    function automatic req_t random_request(input int lo, input int hi);
        req_t r;
        int   band_lo;
        int   band_hi;
        r.mode_sel     = 3'($urandom);
        r.fan_sel      = 2'($urandom);
        r.setpoint     = 8'($urandom);
        r.toggle_flags = 6'($urandom);
        r.power_on     = 1'($urandom);
        r.hvane        = 4'($urandom);
        r.sensor_on    = 1'($urandom);
        if ($urandom_range(1, 0) == 1)
        begin
            band_lo = ((lo < hi) ? lo : hi) - 3;
            band_hi = ((lo > hi) ? lo : hi) + 3;
            if (band_lo < 0)
                band_lo = 0;
            if (band_hi > 255)
                band_hi = 255;
            r.setpoint = 8'($urandom_range(band_hi, band_lo));
        end
        return r;
    endfunction

    // Offers one request word and returns on the falling edge after it was
    // taken. push stays high, so a following call continues the burst.
    task automatic send_request(input req_t r);
        request <= r;
        push    <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // One register access: setup cycle, access cycle, then idle with psel low so
    // that back-to-back accesses never raise and lower psel in the same step.
    task automatic reg_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Writes both limits with junk in the unused upper bits, then reads
    // them back; the checker compares the read data.
    task automatic set_limits(input logic [6:0] lo, input logic [6:0] hi);
        reg_access(1'b1, TEMP_MIN_ADDR, ($urandom & ~32'h7F) | {25'd0, lo});
        reg_access(1'b1, TEMP_MAX_ADDR, ($urandom & ~32'h7F) | {25'd0, hi});
        reg_access(1'b0, TEMP_MIN_ADDR, 32'd0);
        reg_access(1'b0, TEMP_MAX_ADDR, 32'd0);
    endtask

    // Waits until every expected word has been drained, plus a short margin.
    task automatic wait_idle();
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random requests in bursts of one to six words. About a quarter of the
    // bursts run straight into the next one; the rest leave a random gap.
    task automatic send_random(input int count, input int lo, input int hi);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(6, 1);
            if (burst > left)
                burst = left;
            repeat (burst) send_request(random_request(lo, hi));
            left -= burst;
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(40, 1);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        push <= 1'b0;
    endtask

    // Result side: runs of random length, each with its own stall rate
    // (none, light or heavy). Once enough requests have gone in, the drain
    // stops for a long stretch so that the job queue fills and full stalls
    // the sender, which keeps offering words meanwhile.
    initial
    begin : result_drain
        int  run_len;
        int  stall_pct;
        bit  held;
        pop  <= 1'b0;
        held = 1'b0;
        forever
        begin
            if (!held && requests_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                @(negedge clk);
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            case ($urandom_range(2, 0))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                default: stall_pct = 80;
            endcase
            run_len = $urandom_range(200, 20);
            repeat (run_len)
            begin
                @(negedge clk);
                pop <= ($urandom_range(99, 0) >= stall_pct);
            end
        end
    end

    initial
    begin : stimulus
        int lo;
        int hi;
        int phase_lo [PHASES];
        int phase_hi [PHASES];

        // Full range, inverted range (everything collapses to the maximum),
        // a typical band, a mildly inverted band, a single degree, and one
        // random pair.
        phase_lo = '{0, 127, 16, 40, 25, 0};
        phase_hi = '{127, 0, 30, 20, 25, 0};
        phase_lo[PHASES - 1] = $urandom_range(127, 0);
        phase_hi[PHASES - 1] = $urandom_range(127, 0);

        rst_n   <= 1'b0;
        request <= '0;
        push    <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words under the reset limits of 10 to 32 degrees, sent
        // back to back: every mode including off and the two unused codes,
        // every fan speed, quiet overriding the fan, each flag alone, all
        // flags together, the ignored flag bit, setpoint extremes and both
        // clamp edges, and the vane and sensor at both values.
        send_request(make_request(MODE_OFF,    FAN_AUTO, 8'd0,   6'h00, 1'b0, 4'h0, 1'b0));
        send_request(make_request(MODE_COOL,   FAN_LOW,  8'd255, 6'h3F, 1'b1, 4'hF, 1'b1));
        send_request(make_request(MODE_AUTO,   FAN_MED,  8'd10,  6'h02, 1'b1, 4'h0, 1'b0));
        send_request(make_request(MODE_DRY,    FAN_HIGH, 8'd32,  6'h04, 1'b0, 4'hF, 1'b0));
        send_request(make_request(MODE_HEAT,   FAN_AUTO, 8'd33,  6'h08, 1'b0, 4'h0, 1'b1));
        send_request(make_request(MODE_FAN,    FAN_MED,  8'd9,   6'h10, 1'b1, 4'h5, 1'b0));
        send_request(make_request(MODE_SPARE6, FAN_HIGH, 8'd21,  6'h20, 1'b0, 4'hF, 1'b1));
        send_request(make_request(MODE_SPARE7, FAN_LOW,  8'd128, 6'h01, 1'b1, 4'h0, 1'b0));
        send_request(make_request(MODE_COOL,   FAN_HIGH, 8'd24,  6'h08, 1'b1, 4'h0, 1'b0));
        send_request(make_request(MODE_HEAT,   FAN_MED,  8'd127, 6'h3E, 1'b1, 4'hA, 1'b0));
        send_request(make_request(MODE_AUTO,   FAN_AUTO, 8'd20,  6'h00, 1'b0, 4'h0, 1'b1));
        push <= 1'b0;
        wait_idle();

        // Random phases, each under its own pair of limits.
        for (int p = 0; p < PHASES; p++)
        begin
            lo = phase_lo[p];
            hi = phase_hi[p];
            set_limits(7'(lo), 7'(hi));
            send_random(PHASE_ITEMS, lo, hi);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d requests and %0d frame words under the reset limits and %0d",
                 requests_seen, words_seen, PHASES);
        $display("written limit pairs, including inverted ranges and a long result hold-off.");
        if (mismatches == 0 && outstanding == 0)
            $display("ac_ir_frame_builder test passed");
        else
            $display("ac_ir_frame_builder test failed");
        $finish;
    end

endmodule

### ac_ir_frame_builder.f
rtl/acfb_pkg.sv
rtl/acfb_front.sv
rtl/acfb_queue.sv
rtl/acfb_back.sv
rtl/ac_ir_frame_builder.sv
tb/sv/acfb_frame_checker.sv
tb/sv/tb_ac_ir_frame_builder.sv
